// ===== sv/safp_pkg.sv =====
// ----------------------------------------------------------------------------
// safp_pkg
// types and constants shared by the acknowledge frame parser and its channels
// ----------------------------------------------------------------------------
package safp_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CNT_W      = 6;

  localparam logic [BYTE_W-1:0]  START_HI      = 8'hEF;
  localparam logic [BYTE_W-1:0]  START_LO      = 8'h01;
  localparam logic [BYTE_W-1:0]  TYPE_ACK      = 8'h07;
  localparam logic [LEN_W-1:0]   MIN_LEN       = 16'd3;
  localparam logic [LEN_W-1:0]   MAX_PAYLOAD   = 16'd32;
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 16'd900;
  localparam logic [TICK_W-1:0]  TICK_MAX      = 16'hFFFF;

  // header byte positions
  localparam logic [CNT_W-1:0] IDX_START_HI = 6'd0;
  localparam logic [CNT_W-1:0] IDX_START_LO = 6'd1;
  localparam logic [CNT_W-1:0] IDX_TYPE     = 6'd6;
  localparam logic [CNT_W-1:0] IDX_LEN_HI   = 6'd7;
  localparam logic [CNT_W-1:0] IDX_LEN_LO   = 6'd8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_BAD_SUM    = 3'd3,
    ST_TIMEOUT    = 3'd4
  } status_t;

endpackage

// ===== sv/safp_in_if.sv =====
// ----------------------------------------------------------------------------
// safp_in_if
// input channel: one received byte, tick or start event per transfer
// ----------------------------------------------------------------------------
interface safp_in_if
  import safp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ===== sv/safp_out_if.sv =====
// ----------------------------------------------------------------------------
// safp_out_if
// result channel: one parse outcome per transfer
// ----------------------------------------------------------------------------
interface safp_out_if
  import safp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   ack_byte;
  logic [LEN_W-1:0]    frame_length;

  modport source (output valid, output status, output ack_byte, output frame_length,
                  input ready);
  modport sink   (input valid, input status, input ack_byte, input frame_length,
                  output ready);
endinterface

// ===== sv/sensor_ack_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sensor_ack_frame_parser
// parses one acknowledge frame from a serial byte stream after a start event
// ----------------------------------------------------------------------------
// usage
//   in_ch  : one event per transfer: a received byte, a time tick or a start
//            that arms the parser and restarts reception at the first header
//            byte; bytes and ticks while not armed are dropped silently
//   out_ch : one result per finished or failed frame: status, ack code and
//            the length field; the parser disarms after each result
//   cfg_*  : tick_limit, ticks allowed per header or trailer phase; write
//            it only while no frame is in progress
// timing
//   each event is handled in the cycle it is taken; a result appears on
//   out_ch in the cycle after the transfer that caused it
//   one event per cycle while out_ch is not stalled; the single output register decides
//   ready: in_ch is ready while that register is empty or being drained
// reset
//   rst_n low clears the parser to not armed, empties the output register
//   and loads tick_limit with 900
// stalls
//   while out_ch is stalled with a result waiting, in_ch ready drops, so no
//   event is taken and no result is lost
// ----------------------------------------------------------------------------
module sensor_ack_frame_parser
  import safp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  safp_in_if.sink           in_ch,
  safp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata
);

  // configuration
  logic [TICK_W-1:0] tick_limit_r;

  // frame state
  logic              armed_r,        armed_nxt;
  logic              in_trailer_r,   in_trailer_nxt;
  logic [CNT_W-1:0]  byte_count_r,   byte_count_nxt;
  logic              header_bad_r,   header_bad_nxt;
  logic [LEN_W-1:0]  length_field_r, length_field_nxt;
  logic [SUM_W-1:0]  running_sum_r,  running_sum_nxt;
  logic [BYTE_W-1:0] first_byte_r,   first_byte_nxt;
  logic [BYTE_W-1:0] sum_high_r,     sum_high_nxt;
  logic [TICK_W-1:0] tick_count_r,   tick_count_nxt;

  // output register
  logic              out_valid_r,    out_valid_nxt;
  status_t           status_r,       status_nxt;
  logic [BYTE_W-1:0] ack_byte_r,     ack_byte_nxt;
  logic [LEN_W-1:0]  frame_len_r,    frame_len_nxt;

  // per-event helpers
  logic              accept;
  logic              emit;
  opcode_t           op;
  logic [BYTE_W-1:0] rx_b;
  logic [TICK_W-1:0] tick_inc;
  logic              hdr_bad;
  logic [LEN_W-1:0]  hdr_len;
  logic [CNT_W:0]    idx_plus2;
  logic [CNT_W:0]    trl_len;
  logic [SUM_W-1:0]  got_sum;

  // take a new event whenever the output register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = opcode_t'(in_ch.opcode);
  assign rx_b        = in_ch.rx_byte;

  // saturating tick counter
  assign tick_inc = (tick_count_r == TICK_MAX) ? tick_count_r : tick_count_r + 1'b1;

  // header checks, including the byte being taken now
  always_comb begin
    hdr_bad = header_bad_r;
    if (byte_count_r == IDX_START_HI && rx_b != START_HI) hdr_bad = 1'b1;
    if (byte_count_r == IDX_START_LO && rx_b != START_LO) hdr_bad = 1'b1;
    if (byte_count_r == IDX_TYPE && rx_b != TYPE_ACK) hdr_bad = 1'b1;
  end

  always_comb begin
    hdr_len = length_field_r;
    if (byte_count_r == IDX_LEN_HI) hdr_len = {rx_b, 8'h00};
    if (byte_count_r == IDX_LEN_LO) hdr_len = {length_field_r[LEN_W-1:BYTE_W], rx_b};
  end

  // in the trailer the length never exceeds the payload limit, so its low bits do
  assign idx_plus2 = {1'b0, byte_count_r} + 7'd2;
  assign trl_len   = length_field_r[CNT_W:0];
  assign got_sum   = {sum_high_r, rx_b};

  // event handling
  always_comb begin
    armed_nxt        = armed_r;
    in_trailer_nxt   = in_trailer_r;
    byte_count_nxt   = byte_count_r;
    header_bad_nxt   = header_bad_r;
    length_field_nxt = length_field_r;
    running_sum_nxt  = running_sum_r;
    first_byte_nxt   = first_byte_r;
    sum_high_nxt     = sum_high_r;
    tick_count_nxt   = tick_count_r;
    emit             = 1'b0;
    status_nxt       = ST_OK;
    ack_byte_nxt     = '0;
    frame_len_nxt    = length_field_r;

    if (accept) begin
      case (op)
        OP_START: begin
          // drop anything in progress and start a fresh frame
          armed_nxt        = 1'b1;
          in_trailer_nxt   = 1'b0;
          byte_count_nxt   = '0;
          header_bad_nxt   = 1'b0;
          length_field_nxt = '0;
          running_sum_nxt  = '0;
          first_byte_nxt   = '0;
          sum_high_nxt     = '0;
          tick_count_nxt   = '0;
        end
        OP_TICK: begin
          if (armed_r) begin
            tick_count_nxt = tick_inc;
            if (tick_inc >= tick_limit_r) begin
              emit          = 1'b1;
              status_nxt    = ST_TIMEOUT;
              // length is reported only once the header was complete
              frame_len_nxt = in_trailer_r ? length_field_r : '0;
            end
          end
        end
        OP_BYTE: begin
          if (armed_r && !in_trailer_r) begin
            header_bad_nxt   = hdr_bad;
            length_field_nxt = hdr_len;
            frame_len_nxt    = hdr_len;
            if (byte_count_r != IDX_LEN_LO) begin
              byte_count_nxt = byte_count_r + 1'b1;
            end else if (hdr_bad) begin
              emit       = 1'b1;
              status_nxt = ST_BAD_HEADER;
            end else if (hdr_len < MIN_LEN || hdr_len > MAX_PAYLOAD) begin
              emit       = 1'b1;
              status_nxt = ST_BAD_LENGTH;
            end else begin
              // sum seeds with type and both length bytes
              running_sum_nxt = SUM_W'(TYPE_ACK) + SUM_W'(hdr_len[LEN_W-1:BYTE_W])
                              + SUM_W'(hdr_len[BYTE_W-1:0]);
              in_trailer_nxt  = 1'b1;
              byte_count_nxt  = '0;
              tick_count_nxt  = '0;
            end
          end else if (armed_r) begin
            if (byte_count_r == '0) first_byte_nxt = rx_b;
            if (idx_plus2 < trl_len) begin
              running_sum_nxt = running_sum_r + SUM_W'(rx_b);
              byte_count_nxt  = byte_count_r + 1'b1;
            end else if (idx_plus2 == trl_len) begin
              sum_high_nxt   = rx_b;
              byte_count_nxt = byte_count_r + 1'b1;
            end else begin
              emit = 1'b1;
              if (got_sum != running_sum_r) begin
                status_nxt = ST_BAD_SUM;
              end else begin
                status_nxt   = ST_OK;
                ack_byte_nxt = (byte_count_r == '0) ? rx_b : first_byte_r;
              end
            end
          end
        end
        default: begin
          // unused opcode: no effect
        end
      endcase
      if (emit) armed_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_limit_r    <= TIMEOUT_RESET;
      armed_r         <= 1'b0;
      in_trailer_r    <= 1'b0;
      byte_count_r    <= '0;
      header_bad_r    <= 1'b0;
      length_field_r  <= '0;
      running_sum_r   <= '0;
      first_byte_r    <= '0;
      sum_high_r      <= '0;
      tick_count_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) tick_limit_r <= cfg_wdata;
      armed_r        <= armed_nxt;
      in_trailer_r   <= in_trailer_nxt;
      byte_count_r   <= byte_count_nxt;
      header_bad_r   <= header_bad_nxt;
      length_field_r <= length_field_nxt;
      running_sum_r  <= running_sum_nxt;
      first_byte_r   <= first_byte_nxt;
      sum_high_r     <= sum_high_nxt;
      tick_count_r   <= tick_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result payload, loaded only when a new result is produced
  always_ff @(posedge clk) begin
    if (emit) begin
      status_r    <= status_nxt;
      ack_byte_r  <= ack_byte_nxt;
      frame_len_r <= frame_len_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.ack_byte     = ack_byte_r;
  assign out_ch.frame_length = frame_len_r;

endmodule
